// File: rtl/msf_pkg.sv
// ============================================================================
// msf_pkg
// Shared constants, types and the arctangent table of the Schmid factor unit.
// ============================================================================
package msf_pkg;

    // Default load / plane / direction component width (signed Q3.12)
    localparam int VECTOR_BITS_DEF = 16;

    // Symmetry operators: identity, two-fold about z, two four-folds about z
    localparam int NUM_OPS = 4;
    localparam int OP_BITS = 2;
    localparam int NUM_VECS = 2;          // plane normal and slip direction

    // Cosine: Q0.16 with the value 1.0 allowed
    localparam int COS_BITS = 16;
    localparam int COS_W = COS_BITS + 1;
    localparam int QUOT_BITS = 2 * COS_BITS + 1;
    localparam int DIV_STEPS = QUOT_BITS;
    localparam int SQRT_COS_STEPS = COS_BITS + 1;
    localparam int LANE_LAT = DIV_STEPS + SQRT_COS_STEPS;

    // Product of two cosines, Q0.32
    localparam int PROD_W = 2 * COS_W;
    localparam int OUT_W = 16;

    // Arccos: x in Q0.30, y = sqrt(2^60 - x^2), 24 CORDIC steps in Q2.24
    localparam int ACOS_X_SHIFT = 14;
    localparam int ACOS_X_W = COS_W + ACOS_X_SHIFT;
    localparam int ACOS_RAD_W = 2 * ACOS_X_W - 1;
    localparam int ACOS_SQRT_STEPS = ACOS_X_W;
    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_W = ACOS_X_W + 3;
    localparam int ANGLE_W = 28;
    localparam int ANGLE_ROUND_SHIFT = 10;

    // Register stages of the pipeline, in order
    localparam int FRONT_STAGES = 5;
    localparam int SELECT_STAGES = 3;
    localparam int ACOS_PREP_STAGES = 2;
    localparam int OUT_STAGES = 1;
    localparam int ACOS_DLY = 1 + ACOS_SQRT_STEPS + CORDIC_STEPS;
    localparam int LATENCY = FRONT_STAGES + LANE_LAT + SELECT_STAGES + ACOS_PREP_STAGES
                           + ACOS_SQRT_STEPS + CORDIC_STEPS + OUT_STAGES;

    typedef logic [OP_BITS-1:0] op_idx_t;

    // Flags that ride along the cosine lanes
    typedef struct packed {
        logic degen;
        logic plane_neg;
    } tag_t;

    // Result fields that ride along the arccos lanes
    typedef struct packed {
        logic [OUT_W-1:0] factor;
        op_idx_t          sys;
        logic             zero;
        logic             degen;
    } res_tag_t;

    // round(atan(2^-i) * 2^24)
    function automatic logic [ANGLE_W-1:0] atan_q24(input int unsigned idx);
        logic [ANGLE_W-1:0] val;
        case (idx)
            0:       val = ANGLE_W'(13176795);
            1:       val = ANGLE_W'(7778716);
            2:       val = ANGLE_W'(4110060);
            3:       val = ANGLE_W'(2086331);
            4:       val = ANGLE_W'(1047214);
            5:       val = ANGLE_W'(524117);
            6:       val = ANGLE_W'(262123);
            7:       val = ANGLE_W'(131069);
            8:       val = ANGLE_W'(65536);
            9:       val = ANGLE_W'(32768);
            10:      val = ANGLE_W'(16384);
            11:      val = ANGLE_W'(8192);
            12:      val = ANGLE_W'(4096);
            13:      val = ANGLE_W'(2048);
            14:      val = ANGLE_W'(1024);
            15:      val = ANGLE_W'(512);
            16:      val = ANGLE_W'(256);
            17:      val = ANGLE_W'(128);
            18:      val = ANGLE_W'(64);
            19:      val = ANGLE_W'(32);
            20:      val = ANGLE_W'(16);
            21:      val = ANGLE_W'(8);
            22:      val = ANGLE_W'(4);
            23:      val = ANGLE_W'(2);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// File: rtl/msf_cos_lane.sv
// ============================================================================
// msf_cos_lane
// Pipelined cosine: floor(sqrt(floor(dot^2 * 2^32 / den))), one bit a stage.
// ============================================================================
module msf_cos_lane
    import msf_pkg::*;
#(
    parameter int VECTOR_BITS = VECTOR_BITS_DEF
)
(
    input  logic                     clk,
    input  logic [4*VECTOR_BITS-1:0] den,
    input  logic [4*VECTOR_BITS-1:0] dot_sq,
    output logic [COS_W-1:0]         cos_val
);

    localparam int QW  = 4 * VECTOR_BITS;
    localparam int NW  = QW + 2 * COS_BITS;
    localparam int SQW = QUOT_BITS + 1;

    logic [NW-1:0]        rem_reg [DIV_STEPS];
    logic [QW-1:0]        den_reg [DIV_STEPS];
    logic [QUOT_BITS-1:0] quo_reg [DIV_STEPS];
    logic [SQW-1:0]       srem_reg [SQRT_COS_STEPS];
    logic [SQW-1:0]       root_reg [SQRT_COS_STEPS];

    // Restoring division, quotient MSB first
    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
        localparam int SH = DIV_STEPS - 1 - s;
        logic [NW-1:0]        rem_in;
        logic [QW-1:0]        den_in;
        logic [QUOT_BITS-1:0] quo_in;
        logic [NW-1:0]        trial;
        logic [NW-1:0]        rem_next;
        logic [QUOT_BITS-1:0] quo_next;

        if (s == 0) begin : g_first
            assign rem_in = {dot_sq, {(2 * COS_BITS){1'b0}}};
            assign den_in = den;
            assign quo_in = '0;
        end
        else begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign den_in = den_reg[s-1];
            assign quo_in = quo_reg[s-1];
        end

        assign trial = NW'(den_in) << SH;

        always_comb
        begin
            if (rem_in >= trial)
            begin
                rem_next = rem_in - trial;
                quo_next = quo_in | (QUOT_BITS'(1) << SH);
            end
            else
            begin
                rem_next = rem_in;
                quo_next = quo_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s] <= rem_next;
            den_reg[s] <= den_in;
            quo_reg[s] <= quo_next;
        end
    end

    // Integer square root of the quotient, two radicand bits a stage
    for (genvar t = 0; t < SQRT_COS_STEPS; t++) begin : g_sqrt
        localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (SQRT_COS_STEPS - 1 - t));
        logic [SQW-1:0] rem_in;
        logic [SQW-1:0] root_in;
        logic [SQW-1:0] sum;
        logic [SQW-1:0] srem_next;
        logic [SQW-1:0] root_next;

        if (t == 0) begin : g_first
            assign rem_in  = SQW'(quo_reg[DIV_STEPS-1]);
            assign root_in = '0;
        end
        else begin : g_rest
            assign rem_in  = srem_reg[t-1];
            assign root_in = root_reg[t-1];
        end

        assign sum = root_in + BIT;

        always_comb
        begin
            if (rem_in >= sum)
            begin
                srem_next = rem_in - sum;
                root_next = (root_in >> 1) + BIT;
            end
            else
            begin
                srem_next = rem_in;
                root_next = root_in >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            srem_reg[t] <= srem_next;
            root_reg[t] <= root_next;
        end
    end

    assign cos_val = root_reg[SQRT_COS_STEPS-1][COS_W-1:0];

endmodule

// File: rtl/max_schmid_factor_over_symmetry_unit.sv
// ============================================================================
// max_schmid_factor_over_symmetry_unit
// Largest Schmid factor over the four tetragonal rotations about z, with the
// arccos of the winning plane and direction cosines.
//
// One beat is taken on every cycle that start is high (busy is always low),
// and its result appears on the strobe done, one result per beat, in order.
// The pipeline holds five front stages of products and sums, the 33-step
// divider and the 17-step root of each cosine lane, three selection stages,
// two arccos preparation stages, a 31-step root for the sine and 24 CORDIC
// steps, plus the output register. Results are not held: the receiver must
// take each one in the cycle that done is high.
// ============================================================================
module max_schmid_factor_over_symmetry_unit
    import msf_pkg::*;
#(
    parameter int VECTOR_BITS = VECTOR_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [VECTOR_BITS-1:0] load_x,
    input  logic signed [VECTOR_BITS-1:0] load_y,
    input  logic signed [VECTOR_BITS-1:0] load_z,
    input  logic signed [VECTOR_BITS-1:0] plane_x,
    input  logic signed [VECTOR_BITS-1:0] plane_y,
    input  logic signed [VECTOR_BITS-1:0] plane_z,
    input  logic signed [VECTOR_BITS-1:0] dir_x,
    input  logic signed [VECTOR_BITS-1:0] dir_y,
    input  logic signed [VECTOR_BITS-1:0] dir_z,
    output logic                          done,
    output logic [OUT_W-1:0]              schmid_factor,
    output logic [OP_BITS-1:0]            slip_system,
    output logic [OUT_W-1:0]              plane_angle,
    output logic [OUT_W-1:0]              direction_angle,
    output logic                          degenerate
);

    localparam int VB = VECTOR_BITS;
    localparam int PW = 2 * VB;
    localparam int QW = 2 * PW;
    localparam int NUM_MUL = NUM_VECS * NUM_OPS + NUM_VECS;
    localparam int NUM_LANES = NUM_VECS * NUM_OPS;
    localparam int SQ2_W = ACOS_RAD_W + 1;

    logic accept;
    logic [LATENCY-1:0] vld_reg;

    logic signed [VB-1:0] lvec [3];
    logic signed [VB-1:0] pvec [NUM_VECS][3];

    // Stage A: squares and cross products
    logic signed [PW-1:0] sq_reg [9];
    logic signed [PW-1:0] xp_reg [NUM_VECS][5];
    logic                 pz_a_reg;

    // Stage B: magnitudes squared and partial dot terms
    logic [PW-1:0]        sum_reg [3];
    logic signed [PW:0]   ta_reg [NUM_VECS];
    logic signed [PW:0]   tb_reg [NUM_VECS];
    logic signed [PW:0]   tc_reg [NUM_VECS];
    logic                 pz_b_reg;

    // Stage C: absolute dot products per operator
    logic [PW-1:0]        dot_next [NUM_VECS][NUM_OPS];
    logic [PW-1:0]        dot_reg [NUM_VECS][NUM_OPS];
    logic [PW-1:0]        sum_c_reg [3];
    tag_t                 tag_c_reg;

    // Stages D, E: wide products from half-width partial products
    logic [PW-1:0]        mop_a [NUM_MUL];
    logic [PW-1:0]        mop_b [NUM_MUL];
    logic [PW-1:0]        pp_reg [NUM_MUL][4];
    logic [QW-1:0]        wide_reg [NUM_MUL];
    tag_t                 tag_d_reg;
    tag_t                 tag_e_reg;

    // Cosine lanes
    logic [COS_W-1:0]     cos_w [NUM_LANES];
    tag_t                 tag_dly_reg [LANE_LAT];
    tag_t                 tag_lane;

    // Stages F, G, H: selection
    logic [PROD_W-1:0]    prodf_reg [NUM_OPS];
    logic [COS_W-1:0]     cpf_reg [NUM_OPS];
    logic [COS_W-1:0]     cdf_reg [NUM_OPS];
    tag_t                 tag_f_reg;
    logic [PROD_W-1:0]    pprod_reg [2];
    op_idx_t              pidx_reg [2];
    logic [COS_W-1:0]     pcp_reg [2];
    logic [COS_W-1:0]     pcd_reg [2];
    tag_t                 tag_g_reg;
    logic [PROD_W-1:0]    best_reg;
    op_idx_t              sys_reg;
    logic [COS_W-1:0]     bcos_reg [2];
    tag_t                 tag_h_reg;

    // Stage I, J: factor rounding, x and x^2, radicand
    logic [PROD_W:0]      fsum;
    logic [OUT_W-1:0]     factor_next;
    res_tag_t             res_i_reg;
    logic [ACOS_X_W-1:0]  ax_i_reg [2];
    logic [2*ACOS_X_W-1:0] axsq_reg [2];
    logic [ACOS_X_W-1:0]  ax_j_reg [2];
    logic [ACOS_RAD_W-1:0] rad_reg [2];
    res_tag_t             res_dly_reg [ACOS_DLY];

    logic [ANGLE_W-1:0]   zfin [2];
    logic [OUT_W-1:0]     angle_next [2];

    logic [OUT_W-1:0]     factor_reg;
    op_idx_t              slip_reg;
    logic [OUT_W-1:0]     pangle_reg;
    logic [OUT_W-1:0]     dangle_reg;
    logic                 degen_reg;

    // The pipeline never stalls
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign lvec[0]    = load_x;
    assign lvec[1]    = load_y;
    assign lvec[2]    = load_z;
    assign pvec[0][0] = plane_x;
    assign pvec[0][1] = plane_y;
    assign pvec[0][2] = plane_z;
    assign pvec[1][0] = dir_x;
    assign pvec[1][1] = dir_y;
    assign pvec[1][2] = dir_z;

    // Valid bits travel down the whole pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LATENCY-2:0], accept};
    end

    // Stage A
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            sq_reg[k]     <= lvec[k] * lvec[k];
            sq_reg[3 + k] <= pvec[0][k] * pvec[0][k];
            sq_reg[6 + k] <= pvec[1][k] * pvec[1][k];
        end
        for (int v = 0; v < NUM_VECS; v++)
        begin
            xp_reg[v][0] <= lvec[0] * pvec[v][0];
            xp_reg[v][1] <= lvec[1] * pvec[v][1];
            xp_reg[v][2] <= lvec[0] * pvec[v][1];
            xp_reg[v][3] <= lvec[1] * pvec[v][0];
            xp_reg[v][4] <= lvec[2] * pvec[v][2];
        end
        pz_a_reg <= plane_z[VB-1];
    end

    // Stage B: a = xx + yy, b = x*y' - y*x', c = zz
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
            sum_reg[k] <= PW'($unsigned(sq_reg[3*k]) + $unsigned(sq_reg[3*k + 1])
                              + $unsigned(sq_reg[3*k + 2]));
        for (int v = 0; v < NUM_VECS; v++)
        begin
            ta_reg[v] <= (PW+1)'(xp_reg[v][0]) + (PW+1)'(xp_reg[v][1]);
            tb_reg[v] <= (PW+1)'(xp_reg[v][2]) - (PW+1)'(xp_reg[v][3]);
            tc_reg[v] <= (PW+1)'(xp_reg[v][4]);
        end
        pz_b_reg <= pz_a_reg;
    end

    // Stage C: |L.Mv| for each rotation
    always_comb
    begin
        logic signed [PW+1:0] s;
        logic signed [PW+1:0] m;
        for (int v = 0; v < NUM_VECS; v++)
        begin
            for (int op = 0; op < NUM_OPS; op++)
            begin
                case (op)
                    0:       s = (PW+2)'(tc_reg[v]) + (PW+2)'(ta_reg[v]);
                    1:       s = (PW+2)'(tc_reg[v]) - (PW+2)'(ta_reg[v]);
                    2:       s = (PW+2)'(tc_reg[v]) + (PW+2)'(tb_reg[v]);
                    default: s = (PW+2)'(tc_reg[v]) - (PW+2)'(tb_reg[v]);
                endcase
                m = s[PW+1] ? -s : s;
                dot_next[v][op] = m[PW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dot_reg   <= dot_next;
        sum_c_reg <= sum_reg;
        tag_c_reg.degen     <= (sum_reg[0] == '0) || (sum_reg[1] == '0) || (sum_reg[2] == '0);
        tag_c_reg.plane_neg <= pz_b_reg;
    end

    // Stage D, E: dot^2 for every lane and |L|^2|P|^2, |L|^2|D|^2
    for (genvar k = 0; k < NUM_MUL; k++) begin : g_mul
        if (k < NUM_LANES) begin : g_dot
            assign mop_a[k] = dot_reg[k / NUM_OPS][k % NUM_OPS];
            assign mop_b[k] = dot_reg[k / NUM_OPS][k % NUM_OPS];
        end
        else begin : g_den
            assign mop_a[k] = sum_c_reg[0];
            assign mop_b[k] = sum_c_reg[k - NUM_LANES + 1];
        end

        always_ff @(posedge clk)
        begin
            pp_reg[k][0] <= mop_a[k][PW-1:VB] * mop_b[k][PW-1:VB];
            pp_reg[k][1] <= mop_a[k][PW-1:VB] * mop_b[k][VB-1:0];
            pp_reg[k][2] <= mop_a[k][VB-1:0] * mop_b[k][PW-1:VB];
            pp_reg[k][3] <= mop_a[k][VB-1:0] * mop_b[k][VB-1:0];
            wide_reg[k]  <= (QW'(pp_reg[k][0]) << PW)
                          + ((QW'(pp_reg[k][1]) + QW'(pp_reg[k][2])) << VB)
                          + QW'(pp_reg[k][3]);
        end
    end

    always_ff @(posedge clk)
    begin
        tag_d_reg <= tag_c_reg;
        tag_e_reg <= tag_d_reg;
    end

    // Cosine lanes: plane lanes first, then direction lanes
    for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
        msf_cos_lane #(
            .VECTOR_BITS (VECTOR_BITS)
        ) u_lane (
            .clk     (clk),
            .den     (wide_reg[NUM_LANES + k / NUM_OPS]),
            .dot_sq  (wide_reg[k]),
            .cos_val (cos_w[k])
        );
    end

    // Flags follow the lanes
    always_ff @(posedge clk)
    begin
        tag_dly_reg[0] <= tag_e_reg;
        for (int i = 1; i < LANE_LAT; i++)
            tag_dly_reg[i] <= tag_dly_reg[i-1];
    end
    assign tag_lane = tag_dly_reg[LANE_LAT-1];

    // Stage F: factor per rotation; a rotated plane with negative z is skipped
    always_ff @(posedge clk)
    begin
        for (int op = 0; op < NUM_OPS; op++)
        begin
            prodf_reg[op] <= tag_lane.plane_neg ? '0 : cos_w[op] * cos_w[NUM_OPS + op];
            cpf_reg[op]   <= cos_w[op];
            cdf_reg[op]   <= cos_w[NUM_OPS + op];
        end
        tag_f_reg <= tag_lane;
    end

    // Stage G: pairwise max, lower index wins ties
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 2; j++)
        begin
            if (prodf_reg[2*j + 1] > prodf_reg[2*j])
            begin
                pprod_reg[j] <= prodf_reg[2*j + 1];
                pidx_reg[j]  <= op_idx_t'(2*j + 1);
                pcp_reg[j]   <= cpf_reg[2*j + 1];
                pcd_reg[j]   <= cdf_reg[2*j + 1];
            end
            else
            begin
                pprod_reg[j] <= prodf_reg[2*j];
                pidx_reg[j]  <= op_idx_t'(2*j);
                pcp_reg[j]   <= cpf_reg[2*j];
                pcd_reg[j]   <= cdf_reg[2*j];
            end
        end
        tag_g_reg <= tag_f_reg;
    end

    // Stage H: final max
    always_ff @(posedge clk)
    begin
        if (pprod_reg[1] > pprod_reg[0])
        begin
            best_reg    <= pprod_reg[1];
            sys_reg     <= pidx_reg[1];
            bcos_reg[0] <= pcp_reg[1];
            bcos_reg[1] <= pcd_reg[1];
        end
        else
        begin
            best_reg    <= pprod_reg[0];
            sys_reg     <= pidx_reg[0];
            bcos_reg[0] <= pcp_reg[0];
            bcos_reg[1] <= pcd_reg[0];
        end
        tag_h_reg <= tag_g_reg;
    end

    // Stage I: round the factor half up to Q0.16 and saturate; square x
    assign fsum = (PROD_W+1)'(best_reg) + (PROD_W+1)'(1 << (COS_BITS - 1));
    always_comb
    begin
        if (fsum[PROD_W:COS_BITS] > (PROD_W+1-COS_BITS)'({OUT_W{1'b1}}))
            factor_next = '1;
        else
            factor_next = fsum[COS_BITS+OUT_W-1:COS_BITS];
    end

    always_ff @(posedge clk)
    begin
        res_i_reg.factor <= factor_next;
        res_i_reg.sys    <= sys_reg;
        res_i_reg.zero   <= tag_h_reg.degen || (best_reg == '0);
        res_i_reg.degen  <= tag_h_reg.degen;
        for (int g = 0; g < 2; g++)
        begin
            ax_i_reg[g] <= {bcos_reg[g], {ACOS_X_SHIFT{1'b0}}};
            axsq_reg[g] <= {bcos_reg[g], {ACOS_X_SHIFT{1'b0}}}
                         * {bcos_reg[g], {ACOS_X_SHIFT{1'b0}}};
        end
    end

    // Stage J: radicand 2^60 - x^2
    always_ff @(posedge clk)
    begin
        for (int g = 0; g < 2; g++)
        begin
            ax_j_reg[g] <= ax_i_reg[g];
            rad_reg[g]  <= ACOS_RAD_W'((SQ2_W'(1) << (2 * ACOS_X_W - 2)) - SQ2_W'(axsq_reg[g]));
        end
    end

    // Result fields follow the arccos lanes
    always_ff @(posedge clk)
    begin
        res_dly_reg[0] <= res_i_reg;
        for (int i = 1; i < ACOS_DLY; i++)
            res_dly_reg[i] <= res_dly_reg[i-1];
    end

    // Arccos lanes: 0 for the plane cosine, 1 for the direction cosine
    for (genvar g = 0; g < 2; g++) begin : g_acos
        logic [SQ2_W-1:0]           srem_reg [ACOS_SQRT_STEPS];
        logic [SQ2_W-1:0]           sroot_reg [ACOS_SQRT_STEPS];
        logic [ACOS_X_W-1:0]        sx_reg [ACOS_SQRT_STEPS];
        logic signed [CORDIC_W-1:0] cx_reg [CORDIC_STEPS];
        logic signed [CORDIC_W-1:0] cy_reg [CORDIC_STEPS];
        logic signed [ANGLE_W-1:0]  cz_reg [CORDIC_STEPS];
        logic [ANGLE_W-1:0]         zclamp;
        logic [ANGLE_W-1:0]         zround;

        // y = floor(sqrt(radicand)), two bits a stage
        for (genvar t = 0; t < ACOS_SQRT_STEPS; t++) begin : g_sqrt
            localparam logic [SQ2_W-1:0] BIT = SQ2_W'(1) << (2 * (ACOS_SQRT_STEPS - 1 - t));
            logic [SQ2_W-1:0]    rem_in;
            logic [SQ2_W-1:0]    root_in;
            logic [ACOS_X_W-1:0] x_in;
            logic [SQ2_W-1:0]    sum;
            logic [SQ2_W-1:0]    srem_next;
            logic [SQ2_W-1:0]    sroot_next;

            if (t == 0) begin : g_first
                assign rem_in  = SQ2_W'(rad_reg[g]);
                assign root_in = '0;
                assign x_in    = ax_j_reg[g];
            end
            else begin : g_rest
                assign rem_in  = srem_reg[t-1];
                assign root_in = sroot_reg[t-1];
                assign x_in    = sx_reg[t-1];
            end

            assign sum = root_in + BIT;

            always_comb
            begin
                if (rem_in >= sum)
                begin
                    srem_next  = rem_in - sum;
                    sroot_next = (root_in >> 1) + BIT;
                end
                else
                begin
                    srem_next  = rem_in;
                    sroot_next = root_in >> 1;
                end
            end

            always_ff @(posedge clk)
            begin
                srem_reg[t]  <= srem_next;
                sroot_reg[t] <= sroot_next;
                sx_reg[t]    <= x_in;
            end
        end

        // CORDIC vectoring, clockwise while y >= 0
        for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
            localparam logic signed [ANGLE_W-1:0] ATAN = atan_q24(i);
            logic signed [CORDIC_W-1:0] x_in;
            logic signed [CORDIC_W-1:0] y_in;
            logic signed [ANGLE_W-1:0]  z_in;
            logic signed [CORDIC_W-1:0] dx;
            logic signed [CORDIC_W-1:0] dy;

            if (i == 0) begin : g_first
                assign x_in = CORDIC_W'(sx_reg[ACOS_SQRT_STEPS-1]);
                assign y_in = CORDIC_W'(sroot_reg[ACOS_SQRT_STEPS-1][ACOS_X_W-1:0]);
                assign z_in = '0;
            end
            else begin : g_rest
                assign x_in = cx_reg[i-1];
                assign y_in = cy_reg[i-1];
                assign z_in = cz_reg[i-1];
            end

            assign dx = y_in >>> i;
            assign dy = x_in >>> i;

            always_ff @(posedge clk)
            begin
                if (!y_in[CORDIC_W-1])
                begin
                    cx_reg[i] <= x_in + dx;
                    cy_reg[i] <= y_in - dy;
                    cz_reg[i] <= z_in + ATAN;
                end
                else
                begin
                    cx_reg[i] <= x_in - dx;
                    cy_reg[i] <= y_in + dy;
                    cz_reg[i] <= z_in - ATAN;
                end
            end
        end

        // Clamp at zero, round half up to Q2.14
        assign zfin[g]       = cz_reg[CORDIC_STEPS-1];
        assign zclamp        = zfin[g][ANGLE_W-1] ? '0 : zfin[g];
        assign zround        = zclamp + ANGLE_W'(1 << (ANGLE_ROUND_SHIFT - 1));
        assign angle_next[g] = zround[ANGLE_ROUND_SHIFT+OUT_W-1:ANGLE_ROUND_SHIFT];
    end

    // Output register
    always_ff @(posedge clk)
    begin
        degen_reg <= res_dly_reg[ACOS_DLY-1].degen;
        if (res_dly_reg[ACOS_DLY-1].zero)
        begin
            factor_reg <= '0;
            slip_reg   <= '0;
            pangle_reg <= '0;
            dangle_reg <= '0;
        end
        else
        begin
            factor_reg <= res_dly_reg[ACOS_DLY-1].factor;
            slip_reg   <= res_dly_reg[ACOS_DLY-1].sys;
            pangle_reg <= angle_next[0];
            dangle_reg <= angle_next[1];
        end
    end

    assign done            = vld_reg[LATENCY-1];
    assign schmid_factor   = factor_reg;
    assign slip_system     = slip_reg;
    assign plane_angle     = pangle_reg;
    assign direction_angle = dangle_reg;
    assign degenerate      = degen_reg;

endmodule

// File: rtl/msf_checker.sv
// ============================================================================
// msf_checker
// Port-level checks of the Schmid factor unit, bound to its top level.
// ============================================================================
module msf_checker
    import msf_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic [OUT_W-1:0]   schmid_factor,
    input logic [OP_BITS-1:0] slip_system,
    input logic [OUT_W-1:0]   plane_angle,
    input logic [OUT_W-1:0]   direction_angle,
    input logic               degenerate
);

    // Every accepted beat gives a result after the fixed latency
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted beat produced no result");

    // No result without a beat accepted that long ago
    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without matching beat");

    // A degenerate result carries all-zero fields
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && degenerate) |-> (schmid_factor == '0 && slip_system == '0
                                  && plane_angle == '0 && direction_angle == '0))
        else $error("degenerate result with nonzero fields");

    // Angles stay within range
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (plane_angle <= OUT_W'(51472) && direction_angle <= OUT_W'(51472)))
        else $error("angle out of range");

endmodule

bind max_schmid_factor_over_symmetry_unit msf_checker u_msf_checker (.*);
